// File: rtl/core/pfa_pkg.sv
// Package for the page-frame allocator: sizes, field widths, register
// indexes, operation codes and the controller state type. No dependencies.
`timescale 1ns / 1ps

package pfa_pkg;

   localparam int FRAME_TOTAL = 256;
   localparam int PID_BITS    = 10;

   localparam int FRAME_BITS = $clog2(FRAME_TOTAL);
   localparam int CNT_BITS   = FRAME_BITS + 1;
   localparam int OWNER_BITS = PID_BITS + 1;

   // request and result field widths
   localparam int OP_W       = 1;
   localparam int PROC_W     = 10;
   localparam int PAGES_W    = 9;
   localparam int STATUS_W   = 1;
   localparam int FIRST_W    = 8;
   localparam int FREE_W     = 9;
   localparam int BYTES_W    = 25;
   localparam int TOTAL_W    = 32;
   localparam int RESIDENT_W = 16;

   // configuration port
   localparam int CSR_IDX_W   = 1;
   localparam int CSR_DATA_W  = 17;
   localparam int FRAMES_W    = 9;
   localparam int FBYTES_W    = 17;
   localparam int PROD_W      = CNT_BITS + FBYTES_W;

   localparam logic [CSR_IDX_W-1:0] CSR_FRAMES_IN_USE = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_BYTES   = 1'b1;

   localparam logic [FRAMES_W-1:0] FRAMES_RESET = 9'd256;
   localparam logic [FBYTES_W-1:0] FBYTES_RESET = 17'd4096;

   localparam logic [OP_W-1:0] OP_ALLOC = 1'b0;
   localparam logic [OP_W-1:0] OP_FREE  = 1'b1;

   localparam logic [STATUS_W-1:0] ST_DONE    = 1'b0;
   localparam logic [STATUS_W-1:0] ST_REFUSED = 1'b1;

   typedef enum logic [4:0] {
      S_INIT  = 5'b00001,
      S_IDLE  = 5'b00010,
      S_ALLOC = 5'b00100,
      S_FREE  = 5'b01000,
      S_FIN   = 5'b10000
   } state_type;

endpackage

// File: rtl/core/pfa_if.sv
// Channel interfaces of the page-frame allocator: request, result and
// configuration write. Depends on pfa_pkg for the field widths.
`timescale 1ns / 1ps

interface pfa_req_if;
   logic                         valid;
   logic                         ready;
   logic [pfa_pkg::OP_W-1:0]     operation;
   logic [pfa_pkg::PROC_W-1:0]   process_id;
   logic [pfa_pkg::PAGES_W-1:0]  num_pages;

   modport source (output valid, operation, process_id, num_pages, input ready);
   modport sink   (input valid, operation, process_id, num_pages, output ready);
endinterface

interface pfa_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [pfa_pkg::STATUS_W-1:0]   status;
   logic [pfa_pkg::FIRST_W-1:0]    first_frame;
   logic [pfa_pkg::FREE_W-1:0]     free_frames;
   logic [pfa_pkg::BYTES_W-1:0]    free_bytes;
   logic [pfa_pkg::TOTAL_W-1:0]    pages_in;
   logic [pfa_pkg::TOTAL_W-1:0]    pages_out;
   logic [pfa_pkg::RESIDENT_W-1:0] resident_count;

   modport source (output valid, status, first_frame, free_frames, free_bytes,
                   pages_in, pages_out, resident_count, input ready);
   modport sink   (input valid, status, first_frame, free_frames, free_bytes,
                   pages_in, pages_out, resident_count, output ready);
endinterface

interface pfa_csr_if;
   logic                           valid;
   logic                           ready;
   logic [pfa_pkg::CSR_IDX_W-1:0]  index;
   logic [pfa_pkg::CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/core/page_frame_allocator_core.sv
// Top level of the page-frame allocator: free-frame stack and owner table in
// block memories plus the controller. Depends on pfa_pkg and pfa_if.sv.
`timescale 1ns / 1ps

// Page-frame allocator. Frames live on a free stack (one 8-bit entry per
// frame) and each frame has an owner entry (owned bit plus process id), both
// in single-port-write memories with a registered read. An allocate request
// pops num_pages frames, one per cycle, and tags each one with the process.
// A free request sweeps the owner table once in ascending frame order, one
// entry per cycle, pushing matches back on the stack. After reset, and after
// each write of frames_in_use, a clearing pass refills the stack and clears
// the owner table; requests wait during it while configuration writes are
// still taken. The result sits in an output register, so the next request is
// taken while the previous result waits for rsp_if.ready.
module page_frame_allocator_core (
   input  logic   clock,
   input  logic   reset,
   pfa_req_if.sink    req_if,
   pfa_rsp_if.source  rsp_if,
   pfa_csr_if.sink    csr_if
);
   import pfa_pkg::*;

   // memories
   logic [FRAME_BITS-1:0] stack_mem [FRAME_TOTAL];
   logic [OWNER_BITS-1:0] owner_mem [FRAME_TOTAL];

   logic                  stk_we;
   logic [FRAME_BITS-1:0] stk_waddr, stk_wdata, stk_raddr;
   logic [FRAME_BITS-1:0] stk_rdata_ff;
   logic                  own_we;
   logic [FRAME_BITS-1:0] own_waddr, own_raddr;
   logic [OWNER_BITS-1:0] own_wdata;
   logic [OWNER_BITS-1:0] own_rdata_ff;

   // control
   state_type             state_ff, state_in;
   logic [CNT_BITS-1:0]   idx_ff, idx_in;
   logic [CNT_BITS-1:0]   sp_ff, sp_in;
   logic [CNT_BITS-1:0]   remain_ff, remain_in;
   logic                  pend_ff, pend_in;
   logic                  grab_ff, grab_in;
   logic [FRAME_BITS-1:0] pidx_ff, pidx_in;
   logic [PID_BITS-1:0]   pid_ff, pid_in;
   logic [STATUS_W-1:0]   status_ff, status_in;
   logic [FIRST_W-1:0]    first_ff, first_in;
   logic [FRAMES_W-1:0]   frames_ff, frames_in;
   logic [FBYTES_W-1:0]   fbytes_ff, fbytes_in;
   logic [TOTAL_W-1:0]    alloc_total_ff, alloc_total_in;
   logic [TOTAL_W-1:0]    release_total_ff, release_total_in;
   logic [RESIDENT_W-1:0] tally_ff, tally_in;

   // result register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]   rsp_status_ff, rsp_status_in;
   logic [FIRST_W-1:0]    rsp_first_ff, rsp_first_in;
   logic [FREE_W-1:0]     rsp_free_ff, rsp_free_in;
   logic [BYTES_W-1:0]    rsp_bytes_ff, rsp_bytes_in;
   logic [TOTAL_W-1:0]    rsp_in_ff, rsp_in_in;
   logic [TOTAL_W-1:0]    rsp_out_ff, rsp_out_in;
   logic [RESIDENT_W-1:0] rsp_res_ff, rsp_res_in;

   logic                  req_fire;
   logic                  csr_fire;
   logic [CNT_BITS-1:0]   sp_dec;
   logic [CNT_BITS-1:0]   pages_ext;
   logic [PROD_W-1:0]     bytes_prod;
   logic [FRAMES_W-1:0]   frames_clamped;
   logic [OWNER_BITS-1:0] own_match;

   assign req_fire  = req_if.valid && req_if.ready;
   assign csr_fire  = csr_if.valid && csr_if.ready;
   assign sp_dec    = sp_ff - CNT_BITS'(1);
   assign pages_ext = CNT_BITS'(req_if.num_pages);
   assign own_match = {1'b1, pid_ff};

   // clamp the frame count to what the memories hold
   assign frames_clamped = (csr_if.data[FRAMES_W-1:0] > FRAMES_W'(FRAME_TOTAL)) ?
                           FRAMES_W'(FRAME_TOTAL) : csr_if.data[FRAMES_W-1:0];

   assign bytes_prod = PROD_W'(sp_ff) * PROD_W'(fbytes_ff);

   assign req_if.ready = (state_ff == S_IDLE);
   assign csr_if.ready = 1'b1;

   assign rsp_if.valid          = rsp_valid_ff;
   assign rsp_if.status         = rsp_status_ff;
   assign rsp_if.first_frame    = rsp_first_ff;
   assign rsp_if.free_frames    = rsp_free_ff;
   assign rsp_if.free_bytes     = rsp_bytes_ff;
   assign rsp_if.pages_in       = rsp_in_ff;
   assign rsp_if.pages_out      = rsp_out_ff;
   assign rsp_if.resident_count = rsp_res_ff;

   // free-frame stack: one write, one registered read
   always_ff @(posedge clock) begin
      if (stk_we) begin
         stack_mem[stk_waddr] <= stk_wdata;
      end
      stk_rdata_ff <= stack_mem[stk_raddr];
   end

   // owner table: one write, one registered read
   always_ff @(posedge clock) begin
      if (own_we) begin
         owner_mem[own_waddr] <= own_wdata;
      end
      own_rdata_ff <= owner_mem[own_raddr];
   end

   always_comb begin
      state_in         = state_ff;
      idx_in           = idx_ff;
      sp_in            = sp_ff;
      remain_in        = remain_ff;
      pend_in          = 1'b0;
      grab_in          = 1'b0;
      pidx_in          = pidx_ff;
      pid_in           = pid_ff;
      status_in        = status_ff;
      first_in         = first_ff;
      frames_in        = frames_ff;
      fbytes_in        = fbytes_ff;
      alloc_total_in   = alloc_total_ff;
      release_total_in = release_total_ff;
      tally_in         = tally_ff;

      stk_we    = 1'b0;
      stk_waddr = sp_ff[FRAME_BITS-1:0];
      stk_wdata = pidx_ff;
      stk_raddr = sp_dec[FRAME_BITS-1:0];
      own_we    = 1'b0;
      own_waddr = stk_rdata_ff;
      own_wdata = own_match;
      own_raddr = idx_ff[FRAME_BITS-1:0];

      rsp_valid_in  = rsp_valid_ff && !rsp_if.ready;
      rsp_status_in = rsp_status_ff;
      rsp_first_in  = rsp_first_ff;
      rsp_free_in   = rsp_free_ff;
      rsp_bytes_in  = rsp_bytes_ff;
      rsp_in_in     = rsp_in_ff;
      rsp_out_in    = rsp_out_ff;
      rsp_res_in    = rsp_res_ff;

      unique case (state_ff)
         S_INIT: begin
            // refill: frame i at stack slot i for each frame in use, every owner entry cleared
            stk_we    = 1'b1;
            stk_waddr = idx_ff[FRAME_BITS-1:0];
            stk_wdata = (idx_ff < CNT_BITS'(frames_ff)) ? idx_ff[FRAME_BITS-1:0] : '0;
            own_we    = 1'b1;
            own_waddr = idx_ff[FRAME_BITS-1:0];
            own_wdata = '0;
            idx_in    = idx_ff + CNT_BITS'(1);
            if (idx_ff == CNT_BITS'(FRAME_TOTAL - 1)) begin
               sp_in    = CNT_BITS'(frames_ff);
               state_in = S_IDLE;
            end
         end

         S_IDLE: begin
            if (req_fire) begin
               pid_in    = req_if.process_id[PID_BITS-1:0];
               status_in = ST_DONE;
               first_in  = '0;
               if (req_if.operation == OP_ALLOC) begin
                  if (pages_ext > sp_ff) begin
                     // refuse: nothing moves
                     status_in = ST_REFUSED;
                     state_in  = S_FIN;
                  end else begin
                     if (tally_ff != '1) begin
                        tally_in = tally_ff + RESIDENT_W'(1);
                     end
                     // read the top now; pop it too when pages are wanted
                     if (pages_ext != '0) begin
                        sp_in     = sp_dec;
                        remain_in = pages_ext - CNT_BITS'(1);
                        pend_in   = 1'b1;
                        grab_in   = 1'b1;
                     end else begin
                        remain_in = '0;
                        grab_in   = (sp_ff != '0);
                     end
                     state_in = S_ALLOC;
                  end
               end else begin
                  if (tally_ff != '0) begin
                     tally_in = tally_ff - RESIDENT_W'(1);
                  end
                  idx_in   = '0;
                  state_in = S_FREE;
               end
            end
         end

         S_ALLOC: begin
            if (grab_ff) begin
               first_in = FIRST_W'(stk_rdata_ff);
            end
            // tag the frame popped last cycle
            if (pend_ff) begin
               own_we         = 1'b1;
               alloc_total_in = alloc_total_ff + TOTAL_W'(1);
            end
            if (remain_ff != '0) begin
               sp_in     = sp_dec;
               remain_in = remain_ff - CNT_BITS'(1);
               pend_in   = 1'b1;
            end else begin
               state_in = S_FIN;
            end
         end

         S_FREE: begin
            // owner entry read last cycle: release it if the process holds it
            if (pend_ff && (own_rdata_ff == own_match)) begin
               own_we           = 1'b1;
               own_waddr        = pidx_ff;
               own_wdata        = '0;
               release_total_in = release_total_ff + TOTAL_W'(1);
               if (sp_ff < CNT_BITS'(FRAME_TOTAL)) begin
                  stk_we = 1'b1;
                  sp_in  = sp_ff + CNT_BITS'(1);
               end
            end
            if (idx_ff != CNT_BITS'(FRAME_TOTAL)) begin
               pend_in = 1'b1;
               pidx_in = idx_ff[FRAME_BITS-1:0];
               idx_in  = idx_ff + CNT_BITS'(1);
            end else begin
               state_in = S_FIN;
            end
         end

         S_FIN: begin
            // hold until the result register is free
            if (!rsp_valid_ff || rsp_if.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_first_in  = first_ff;
               rsp_free_in   = FREE_W'(sp_ff);
               rsp_bytes_in  = (bytes_prod > PROD_W'({BYTES_W{1'b1}})) ?
                               '1 : bytes_prod[BYTES_W-1:0];
               rsp_in_in     = alloc_total_ff;
               rsp_out_in    = release_total_ff;
               rsp_res_in    = tally_ff;
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_INIT;
            idx_in   = '0;
         end
      endcase

      // register writes; a new frame count restarts the clearing pass
      if (csr_fire) begin
         unique case (csr_if.index)
            CSR_FRAMES_IN_USE: begin
               frames_in = frames_clamped;
               idx_in    = '0;
               state_in  = S_INIT;
            end
            CSR_FRAME_BYTES: begin
               fbytes_in = csr_if.data[FBYTES_W-1:0];
            end
            default: begin
               fbytes_in = fbytes_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= S_INIT;
         idx_ff           <= '0;
         sp_ff            <= '0;
         remain_ff        <= '0;
         pend_ff          <= 1'b0;
         grab_ff          <= 1'b0;
         frames_ff        <= FRAMES_RESET;
         fbytes_ff        <= FBYTES_RESET;
         alloc_total_ff   <= '0;
         release_total_ff <= '0;
         tally_ff         <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff         <= state_in;
         idx_ff           <= idx_in;
         sp_ff            <= sp_in;
         remain_ff        <= remain_in;
         pend_ff          <= pend_in;
         grab_ff          <= grab_in;
         frames_ff        <= frames_in;
         fbytes_ff        <= fbytes_in;
         alloc_total_ff   <= alloc_total_in;
         release_total_ff <= release_total_in;
         tally_ff         <= tally_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pidx_ff       <= pidx_in;
      pid_ff        <= pid_in;
      status_ff     <= status_in;
      first_ff      <= first_in;
      rsp_status_ff <= rsp_status_in;
      rsp_first_ff  <= rsp_first_in;
      rsp_free_ff   <= rsp_free_in;
      rsp_bytes_ff  <= rsp_bytes_in;
      rsp_in_ff     <= rsp_in_in;
      rsp_out_ff    <= rsp_out_in;
      rsp_res_ff    <= rsp_res_in;
   end

   // pops still owed never exceed the frames left on the stack
   a_no_underrun: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ALLOC) |-> (remain_ff <= sp_ff))
      else $error("allocation would pop past the stack bottom");

   // outside the clearing pass the stack never holds more than the managed frames
   a_depth_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_INIT) |-> (sp_ff <= CNT_BITS'(frames_ff)))
      else $error("stack depth exceeds managed frame count");

   // a frame count write always starts a clearing pass
   a_refill: assert property (@(posedge clock) disable iff (reset)
      (csr_fire && (csr_if.index == CSR_FRAMES_IN_USE)) |=> (state_ff == S_INIT))
      else $error("frame count write did not restart the refill");

   // a refused allocation leaves the stack depth alone
   a_refuse_keeps: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FIN && status_ff == ST_REFUSED) |-> $stable(sp_ff))
      else $error("refused allocation moved the stack");

endmodule
